>>> rtl/c3_pkg.sv
// shared types and constants of the 3x3 convolution filter
`timescale 1ns / 1ps
package c3_pkg;

    localparam int C_MAX_WIDTH  = 1024;
    localparam int C_COEF_BITS  = 8;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int H_W          = 13;
    localparam int CFG_W_W      = 11;
    localparam int CFG_H_W      = 13;
    localparam int REG_IDX_W    = 3;

    localparam logic [PIX_W-1:0]   C_PIX_MAX    = 8'd255;
    localparam logic [ROW_W-1:0]   C_ROW_CAP    = 12'd4095;
    localparam logic [H_W-1:0]     C_MAX_HEIGHT = 13'd4096;
    localparam logic [H_W-1:0]     C_MIN_DIM    = 13'd2;
    localparam logic [CFG_W_W-1:0] C_WIDTH_RST  = 11'd480;
    localparam logic [CFG_H_W-1:0] C_HEIGHT_RST = 13'd480;

    // result queue
    localparam int C_FIFO_DEPTH = 8;
    localparam int FIFO_AW      = 3;
    localparam int FIFO_CW      = 4;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;

    // frame position of one output, travels with the window
    typedef struct packed {
        logic valid;
        logic pad_top;
        logic pad_bot;
        logic pad_lft;
        logic pad_rgt;
        logic last;
    } t_tap_ctl;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

endpackage

>>> rtl/c3_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module c3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/c3_mac.sv
// nine masked kernel products, sum and clamp, two register stages
`timescale 1ns / 1ps
module c3_mac #(
    parameter int COEF_BITS = c3_pkg::C_COEF_BITS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  c3_pkg::t_tap_ctl                               i_ctl,
    input  logic [2:0][2:0][c3_pkg::PIX_W-1:0]             i_win,
    input  logic [2:0][3*COEF_BITS-1:0]                    i_coef,
    output c3_pkg::t_result                                o_res,
    output logic [1:0]                                     o_busy
);

    localparam int PROD_W = COEF_BITS + c3_pkg::PIX_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    c3_pkg::t_tap_ctl          r_a_ctl;
    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic signed [PROD_W-1:0]  n_prod [3][3];
    c3_pkg::t_result           r_res;
    logic signed [SUM_W-1:0]   w_sum;
    logic [c3_pkg::PIX_W-1:0]  w_clamp;

    always_comb begin
        logic tap_off;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // zero padding: taps outside the frame drop out
                tap_off = (r == 0 && i_ctl.pad_top) || (r == 2 && i_ctl.pad_bot) ||
                          (c == 0 && i_ctl.pad_lft) || (c == 2 && i_ctl.pad_rgt);
                if (tap_off) begin
                    n_prod[r][c] = '0;
                end else begin
                    n_prod[r][c] = $signed(i_coef[r][c*COEF_BITS +: COEF_BITS]) *
                                   $signed({1'b0, i_win[r][c]});
                end
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_sum = w_sum + r_prod[r][c];
            end
        end
        if (w_sum[SUM_W-1]) begin
            w_clamp = '0;
        end else if (|w_sum[SUM_W-2:c3_pkg::PIX_W]) begin
            w_clamp = c3_pkg::C_PIX_MAX;
        end else begin
            w_clamp = w_sum[c3_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_res   <= '0;
        end else begin
            r_a_ctl     <= i_ctl;
            r_res.valid <= r_a_ctl.valid;
            r_res.pixel <= w_clamp;
            r_res.last  <= r_a_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_res  = r_res;
    assign o_busy = {1'b0, r_a_ctl.valid} + {1'b0, r_res.valid};

endmodule

>>> rtl/conv3x3_zero_pad_clamp.sv
// top level: counters, line stores, window, config registers, result queue
`timescale 1ns / 1ps
// 3x3 convolution over an 8-bit grey raster stream with zero padding and a 0..255
// clamp. One pixel (or flush tick) is taken per clock while the result queue has room; the
// rate is set by the two line stores, each read and written once per pixel through
// one ram port pair. The result for raster position p is offered after input p+W+1
// has been taken, through the line store read, window, product, sum and result queue
// registers. After the last pixel of a frame send W+1 flush ticks; the result of the
// bottom-right pixel carries frame_last. Results wait in an eight-entry queue, so
// input keeps flowing while the output is stalled until the queued results and those
// in the pipeline together fill it. The line stores need no clearing after reset.
// Registers (byte address 4*i): image_width, image_height, coef_row_top,
// coef_row_mid, coef_row_bot; three signed taps per coefficient row, left tap in
// the low bits. Write registers only when idle.
module conv3x3_zero_pad_clamp #(
    parameter int MAX_WIDTH = c3_pkg::C_MAX_WIDTH,
    parameter int COEF_BITS = c3_pkg::C_COEF_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [c3_pkg::PIX_W-1:0]          i_pixel_in,
    // filtered output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [c3_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                              o_frame_last,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [((3*COEF_BITS > 32) ? 6 : 5)-1:0] paddr,
    input  logic [((3*COEF_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((3*COEF_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                              pready
);

    localparam int DATA_W   = (3*COEF_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB = (DATA_W == 64) ? 3 : 2;
    localparam int ADDR_W   = ADDR_LSB + c3_pkg::REG_IDX_W;
    localparam int COEF_W   = 3*COEF_BITS;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CW_W     = COL_W + 1;
    localparam int PW       = c3_pkg::PIX_W;
    localparam int RW       = c3_pkg::ROW_W;
    localparam logic [COEF_W-1:0] COEF_RST = {3{{(COEF_BITS-1){1'b0}}, 1'b1}};

    // config registers
    logic [c3_pkg::CFG_W_W-1:0]   r_image_width;
    logic [c3_pkg::CFG_H_W-1:0]   r_image_height;
    logic [2:0][COEF_W-1:0]       r_coef;
    logic                         w_cfg_wr;
    logic [c3_pkg::REG_IDX_W-1:0] w_reg_idx;

    // frame counters
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [RW-1:0]    r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [RW-1:0]    r_out_row, n_out_row;

    logic [c3_pkg::H_W-1:0] w_w_wide;
    logic [c3_pkg::H_W-1:0] w_h_eff;
    logic [CW_W-1:0]        w_w_eff;
    logic [CW_W-1:0]        w_w_m1;
    logic [RW-1:0]          w_h_m1;
    logic [CW_W-1:0]        w_col_p1;
    logic [CW_W-1:0]        w_ocol_p1;
    logic                   w_acc;
    logic                   w_emit;
    logic                   w_last;
    logic [PW-1:0]          w_pix;
    c3_pkg::t_tap_ctl       w_ctl;

    // line store stage
    logic                   r_s1_valid;
    logic [PW-1:0]          r_s1_pix;
    logic [COL_W-1:0]       r_s1_col;
    logic                   r_s1_fwd;
    c3_pkg::t_tap_ctl       r_s1_ctl;
    logic [PW-1:0]          r_lo_hold;
    logic [PW-1:0]          w_up_rd;
    logic [PW-1:0]          w_lo_rd;
    logic [PW-1:0]          w_up;

    // window stage
    logic [2:0][2:0][PW-1:0] r_win, n_win;
    c3_pkg::t_tap_ctl        r_wctl;

    c3_pkg::t_result         w_res;
    logic [1:0]              w_mac_busy;

    // result queue
    logic [PW-1:0]              r_fifo_pix  [c3_pkg::C_FIFO_DEPTH];
    logic                       r_fifo_last [c3_pkg::C_FIFO_DEPTH];
    logic [c3_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [c3_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [c3_pkg::FIFO_CW-1:0] r_count, n_count;
    logic [c3_pkg::FIFO_CW-1:0] w_used;
    logic                       w_pop;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = paddr[ADDR_W-1:ADDR_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= c3_pkg::C_WIDTH_RST;
            r_image_height <= c3_pkg::C_HEIGHT_RST;
            r_coef         <= {3{COEF_RST}};
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                c3_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[c3_pkg::CFG_W_W-1:0];
                c3_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[c3_pkg::CFG_H_W-1:0];
                c3_pkg::REG_COEF_TOP:     r_coef[0]      <= pwdata[COEF_W-1:0];
                c3_pkg::REG_COEF_MID:     r_coef[1]      <= pwdata[COEF_W-1:0];
                c3_pkg::REG_COEF_BOT:     r_coef[2]      <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            c3_pkg::REG_IMAGE_WIDTH:  prdata = DATA_W'(r_image_width);
            c3_pkg::REG_IMAGE_HEIGHT: prdata = DATA_W'(r_image_height);
            c3_pkg::REG_COEF_TOP:     prdata = DATA_W'(r_coef[0]);
            c3_pkg::REG_COEF_MID:     prdata = DATA_W'(r_coef[1]);
            c3_pkg::REG_COEF_BOT:     prdata = DATA_W'(r_coef[2]);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- frame sizes in use ----------------
    always_comb begin
        if (c3_pkg::H_W'(r_image_width) < c3_pkg::C_MIN_DIM) begin
            w_w_wide = c3_pkg::C_MIN_DIM;
        end else if (c3_pkg::H_W'(r_image_width) > c3_pkg::H_W'(MAX_WIDTH)) begin
            w_w_wide = c3_pkg::H_W'(MAX_WIDTH);
        end else begin
            w_w_wide = c3_pkg::H_W'(r_image_width);
        end
        if (r_image_height < c3_pkg::C_MIN_DIM) begin
            w_h_eff = c3_pkg::C_MIN_DIM;
        end else if (r_image_height > c3_pkg::C_MAX_HEIGHT) begin
            w_h_eff = c3_pkg::C_MAX_HEIGHT;
        end else begin
            w_h_eff = r_image_height;
        end
    end

    assign w_w_eff = w_w_wide[CW_W-1:0];
    assign w_w_m1  = w_w_eff - 1'b1;
    assign w_h_m1  = RW'(w_h_eff - 1'b1);

    // ---------------- input side ----------------
    assign w_acc     = i_in_valid & o_in_ready;
    assign w_pix     = i_cmd ? '0 : i_pixel_in;
    assign w_col_p1  = {1'b0, r_in_col} + 1'b1;
    assign w_ocol_p1 = {1'b0, r_out_col} + 1'b1;
    assign w_emit    = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);

    always_comb begin
        w_ctl.valid   = w_emit;
        w_ctl.pad_top = (r_out_row == '0);
        w_ctl.pad_bot = (r_out_row >= w_h_m1);
        w_ctl.pad_lft = (r_out_col == '0);
        w_ctl.pad_rgt = ({1'b0, r_out_col} >= w_w_m1);
        w_ctl.last    = w_ctl.pad_bot & w_ctl.pad_rgt;
    end
    assign w_last = w_ctl.last;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_acc) begin
            if (w_col_p1 >= w_w_eff) begin
                n_in_col = '0;
                if (r_in_row != c3_pkg::C_ROW_CAP) begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = w_col_p1[COL_W-1:0];
            end
            if (w_emit) begin
                if (w_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (w_ocol_p1 >= w_w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = w_ocol_p1[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_wctl     <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_s1_valid <= w_acc;
            r_wctl     <= r_s1_valid ? r_s1_ctl : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pix <= w_pix;
            r_s1_col <= r_in_col;
            r_s1_ctl <= w_ctl;
            // upper store write of the previous transfer lands in the cycle after its read
            r_s1_fwd <= r_s1_valid && (r_s1_col == r_in_col);
        end
        if (r_s1_valid) begin
            r_lo_hold <= w_lo_rd;
            r_win     <= n_win;
        end
    end

    // ---------------- line stores ----------------
    c3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_store_lower (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (r_in_col),
        .i_wdata (w_pix),
        .i_re    (w_acc),
        .i_raddr (r_in_col),
        .o_rdata (w_lo_rd)
    );

    c3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (w_lo_rd),
        .i_re    (w_acc),
        .i_raddr (r_in_col),
        .o_rdata (w_up_rd)
    );

    assign w_up = r_s1_fwd ? r_lo_hold : w_up_rd;

    // ---------------- window ----------------
    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = w_up;
        n_win[1][2] = w_lo_rd;
        n_win[2][2] = r_s1_pix;
    end

    c3_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_wctl),
        .i_win   (r_win),
        .i_coef  (r_coef),
        .o_res   (w_res),
        .o_busy  (w_mac_busy)
    );

    // ---------------- result queue ----------------
    assign w_pop  = o_out_valid & i_out_ready;
    assign w_used = r_count + c3_pkg::FIFO_CW'(r_s1_valid) + c3_pkg::FIFO_CW'(r_wctl.valid)
                  + c3_pkg::FIFO_CW'(w_mac_busy);
    assign o_in_ready = (w_used < c3_pkg::FIFO_CW'(c3_pkg::C_FIFO_DEPTH));

    always_comb begin
        n_count = r_count;
        if (w_res.valid && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_res.valid && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_res.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_fifo_pix[r_wr_ptr]  <= w_res.pixel;
            r_fifo_last[r_wr_ptr] <= w_res.last;
        end
    end

    assign o_out_valid  = (r_count != '0);
    assign o_pixel_out  = r_fifo_pix[r_rd_ptr];
    assign o_frame_last = r_fifo_last[r_rd_ptr];

    // ---------------- checks ----------------
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res.valid && !w_pop && r_count == c3_pkg::FIFO_CW'(c3_pkg::C_FIFO_DEPTH)))
        else $error("result queue overflow");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= c3_pkg::FIFO_CW'(c3_pkg::C_FIFO_DEPTH + 3))
        else $error("queue plus pipeline exceeds credit");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_emit && w_last) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("counters not cleared after last output");

    a_window_follows_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_s1_valid)
        else $error("line store stage lost a transfer");

endmodule

>>> tb/sv/conv3x3_zero_pad_clamp_tb.sv
// self-checking testbench for the 3x3 zero-padded clamped convolution filter
`timescale 1ns / 1ps

import c3_pkg::*;

typedef struct {
    bit [PIX_W-1:0] pixel;
    bit             last;
} t_filt_result;

// line stores, window and raster counters mirrored per accepted input
class conv_scoreboard;
    bit [CFG_W_W-1:0] width_reg;
    bit [CFG_H_W-1:0] height_reg;
    bit [3*C_COEF_BITS-1:0] coef_row [3];
    bit [PIX_W-1:0] upper_line [C_MAX_WIDTH];
    bit [PIX_W-1:0] lower_line [C_MAX_WIDTH];
    bit [PIX_W-1:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    t_filt_result pending_pixels [$];
    int errors;
    int inputs_seen;
    int results_checked;

    function new();
        width_reg  = C_WIDTH_RST;
        height_reg = C_HEIGHT_RST;
        foreach (coef_row[r]) coef_row[r] = 24'h010101;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (win[r, c]) win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        errors = 0;
        inputs_seen = 0;
        results_checked = 0;
    endfunction

    function int unsigned frame_width();
        int unsigned w;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > C_MAX_WIDTH) w = C_MAX_WIDTH;
        return w;
    endfunction

    function int unsigned frame_height();
        int unsigned h;
        h = height_reg;
        if (h < 2) h = 2;
        if (h > int'(C_MAX_HEIGHT)) h = C_MAX_HEIGHT;
        return h;
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, bit [31:0] data);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg   = data[CFG_W_W-1:0];
            REG_IMAGE_HEIGHT: height_reg  = data[CFG_H_W-1:0];
            REG_COEF_TOP:     coef_row[0] = data[3*C_COEF_BITS-1:0];
            REG_COEF_MID:     coef_row[1] = data[3*C_COEF_BITS-1:0];
            REG_COEF_BOT:     coef_row[2] = data[3*C_COEF_BITS-1:0];
            default: ;
        endcase
    endfunction

    function bit [31:0] reg_value(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_IMAGE_WIDTH:  return 32'(width_reg);
            REG_IMAGE_HEIGHT: return 32'(height_reg);
            REG_COEF_TOP:     return 32'(coef_row[0]);
            REG_COEF_MID:     return 32'(coef_row[1]);
            REG_COEF_BOT:     return 32'(coef_row[2]);
            default:          return '0;
        endcase
    endfunction

    function void note_pixel_in(bit cmd, bit [PIX_W-1:0] pix_in);
        int unsigned w, h, col;
        bit emit;
        bit [PIX_W-1:0] pix, up, lo;
        bit signed [C_COEF_BITS-1:0] tap;
        int sum;
        t_filt_result res;
        w = frame_width();
        h = frame_height();
        // a flush tick enters the window as a zero pixel
        pix = cmd ? '0 : pix_in;
        col = in_col;
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        up = '0;
        lo = '0;
        inputs_seen++;
        if (col < C_MAX_WIDTH) begin
            up = upper_line[col];
            lo = lower_line[col];
            upper_line[col] = lo;
            lower_line[col] = pix;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = pix;
        in_col = col + 1;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < C_ROW_CAP) in_row++;
        end
        if (!emit) return;
        sum = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // taps outside the frame are zero
                if (r == 0 && out_row == 0) continue;
                if (r == 2 && out_row >= h - 1) continue;
                if (c == 0 && out_col == 0) continue;
                if (c == 2 && out_col >= w - 1) continue;
                tap = coef_row[r][c*C_COEF_BITS +: C_COEF_BITS];
                sum += int'(tap) * int'(win[r][c]);
            end
        end
        if (sum > int'(C_PIX_MAX)) sum = C_PIX_MAX;
        if (sum < 0) sum = 0;
        res.pixel = sum[PIX_W-1:0];
        res.last  = (out_row >= h - 1) && (out_col >= w - 1);
        pending_pixels.push_back(res);
        if (res.last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task report_mismatch(string what);
        errors++;
        // keep the log short when things go badly wrong
        if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_filtered(bit [PIX_W-1:0] pixel, bit last);
        t_filt_result exp_res;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel=%0d last=%0d", pixel, last));
            return;
        end
        exp_res = pending_pixels.pop_front();
        results_checked++;
        if (pixel !== exp_res.pixel)
            report_mismatch($sformatf("result %0d pixel_out=%0d, want %0d",
                                      results_checked, pixel, exp_res.pixel));
        if (last !== exp_res.last)
            report_mismatch($sformatf("result %0d frame_last=%0d, want %0d",
                                      results_checked, last, exp_res.last));
    endtask
endclass

module conv3x3_zero_pad_clamp_tb;

    localparam int APB_AW        = 5;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 200000;

    typedef enum int {
        K_BOX, K_IDENT, K_POS_MAX, K_NEG_MAX, K_SHARPEN, K_EDGE, K_RANDOM
    } t_kernel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_cmd = 1'b0;
    logic [PIX_W-1:0]   i_pixel_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               o_frame_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    conv_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;
    int cycle_count = 0;
    int frames_run = 0;
    int settings_run = 0;

    conv3x3_zero_pad_clamp u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off whenever hold_seq moves
    initial begin : out_sink
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_filtered(o_pixel_out, o_frame_last);
    end

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input bit [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, data);
        // read the register back at the same address
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.reg_value(idx))
            sb.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                         idx, prdata, sb.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input bit [31:0] wval, input bit [31:0] hval, input t_kernel k);
        bit [31:0] top, mid, bot;
        case (k)
            K_BOX:     begin top = 32'h010101; mid = 32'h010101; bot = 32'h010101; end
            K_IDENT:   begin top = 32'h000000; mid = 32'h000100; bot = 32'h000000; end
            K_POS_MAX: begin top = 32'h7F7F7F; mid = 32'h7F7F7F; bot = 32'h7F7F7F; end
            K_NEG_MAX: begin top = 32'h808080; mid = 32'h808080; bot = 32'h808080; end
            K_SHARPEN: begin top = 32'h00FF00; mid = 32'hFF05FF; bot = 32'h00FF00; end
            K_EDGE:    begin top = 32'hFFFFFF; mid = 32'hFF08FF; bot = 32'hFFFFFF; end
            default:   begin top = $urandom; mid = $urandom; bot = $urandom; end
        endcase
        apb_write(REG_IMAGE_WIDTH, wval);
        apb_write(REG_IMAGE_HEIGHT, hval);
        apb_write(REG_COEF_TOP, top);
        apb_write(REG_COEF_MID, mid);
        apb_write(REG_COEF_BOT, bot);
        settings_run++;
    endtask

    task automatic send_item(input bit cmd, input bit [PIX_W-1:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel_in(cmd, pix);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one whole frame plus its W+1 trailing items, random content
    task automatic run_frame(input int hold_at, input int drain_at);
        int w, h, n_pix, n_all;
        bit cmd;
        bit [PIX_W-1:0] pix;
        w = sb.frame_width();
        h = sb.frame_height();
        n_pix = w * h;
        n_all = n_pix + w + 1;
        for (int i = 0; i < n_all; i++) begin
            if (i == hold_at) hold_seq <= hold_seq + 1;
            if (i == drain_at) wait_idle();
            // rare flush inside the frame; pixels now and then where a flush is due
            if (i < n_pix) cmd = ($urandom_range(99) < 4);
            else cmd = ($urandom_range(99) >= 30);
            case ($urandom_range(9))
                0: pix = '0;
                1: pix = C_PIX_MAX;
                default: pix = $urandom;
            endcase
            send_item(cmd, pix);
        end
        frames_run++;
    endtask

    initial begin : main
        bit [8:0] dir_a [7];
        bit [8:0] dir_b [10];
        int random_items;
        int w, h;
        sb = new();
        // {cmd, pixel}: 2x2 frame, then three flush ticks
        dir_a = '{9'h0FF, 9'h000, 9'h0FF, 9'h001, 9'h100, 9'h100, 9'h100};
        // 3x2 frame with a flush inside it, tail mixes flushes and stray pixels
        dir_b = '{9'h0FF, 9'h1C8, 9'h000, 9'h080, 9'h0FF, 9'h007,
                  9'h0FF, 9'h100, 9'h0AA, 9'h100};
        random_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(0, 0);
        // width 1 and height 0 fall back to 2x2, saturating kernel
        configure(32'h0000_0001, 32'hFFFF_E000, K_POS_MAX);
        foreach (dir_a[i]) send_item(dir_a[i][8], dir_a[i][7:0]);
        wait_idle();
        frames_run++;
        configure(32'd3, 32'd2, K_NEG_MAX);
        foreach (dir_b[i]) send_item(dir_b[i][8], dir_b[i][7:0]);
        wait_idle();
        frames_run++;

        // output held off while input keeps coming, then a drain in mid-frame
        configure(32'd12, 32'd6, K_BOX);
        run_frame(0, 50);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            case (frames_run % 4)
                0: set_idle(0, 0);
                1: set_idle(48, 0);
                2: set_idle(0, 48);
                default: set_idle(22, 22);
            endcase
            w = ($urandom_range(99) < 85) ? $urandom_range(2, 12) : $urandom_range(13, 40);
            h = $urandom_range(2, 6);
            configure(($urandom << CFG_W_W) | w, ($urandom << CFG_H_W) | h,
                      t_kernel'($urandom_range(0, K_RANDOM)));
            run_frame(-1, -1);
            random_items += w * h + w + 1;
            wait_idle();
        end

        $display("ran %0d frames under %0d register settings, %0d inputs, %0d results checked",
                 frames_run, settings_run, sb.inputs_seen, sb.results_checked);
        $display("covered edge padding, clamping both ways, flush and stray tail items, stalls");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/c3_pkg.sv
rtl/c3_ram.sv
rtl/c3_mac.sv
rtl/conv3x3_zero_pad_clamp.sv
tb/sv/conv3x3_zero_pad_clamp_tb.sv
